>>> rtl/core/mer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by mer_ctrl, mer_datapath and the top level; depends on nothing.
package mer_pkg;

	// Multiplier operand width (signed), product width, decision width
	localparam int OPW = 21;
	localparam int PW  = 2 * OPW;
	localparam int DW  = 40;
	// Point coordinate width and internal pixel coordinate width (signed)
	localparam int PTW = 9;
	localparam int CW  = 12;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S1, ST_S2, ST_S3, ST_S4,
		ST_R1A, ST_R1B, ST_R1C, ST_R1D, ST_R1E,
		ST_R2I1, ST_R2I2, ST_R2I3, ST_R2I4, ST_R2I5, ST_R2I6, ST_R2I7, ST_R2I8,
		ST_R2A, ST_R2B, ST_R2C,
		ST_EMIT
	} state_t;

	// Operand pair fed to the shared multiplier
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RA_RA,     // ra * ra
		MUL_RB_RB,     // rb * rb
		MUL_A2_START,  // a2 * (1 - 4y)
		MUL_B2_X1,     // b2 * (x + 1)
		MUL_A2_Y1,     // a2 * (2y - 1)
		MUL_B2_X3,     // b2 * (2x + 3)
		MUL_A2_Y2,     // a2 * (2 - 2y)
		MUL_SQX,       // (2x + 1)^2
		MUL_SQY,       // (y - 1)^2
		MUL_B2_SQ,     // b2 * sq
		MUL_A2_SQ,     // a2 * sq
		MUL_A2_B2,     // a2 * b2
		MUL_A2_Y3,     // a2 * (3 - 2y)
		MUL_B2_X2      // b2 * (2x + 2)
	} mul_sel_t;

	// Datapath register operation; most of them use the registered product
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,       // latch start item
		OP_SET_A2,
		OP_SET_B2,
		OP_DEC_START,  // dec = p + 4*b2
		OP_LHS,        // lhs = 2p
		OP_R1_ADD,     // dec += 4p, remember sign of old dec
		OP_R1_FIN,     // region 1 finish step
		OP_R2_ENTER,   // mark region 2
		OP_SQ,         // sq = p
		OP_DEC_SET,    // dec = p
		OP_DEC_ADD,    // dec += 4p
		OP_DEC_SUB,    // dec -= 4p
		OP_R2_CHK,     // remember sign of dec
		OP_R2_FIN,     // region 2 finish step
		OP_DEACT       // curve done, no pixels
	} op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		op_t      op;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic region2;
		logic lt;         // region 1 test holds
		logic y_zero;
		logic emit_done;  // fourth pixel loaded this cycle
	} status_t;

endpackage

>>> rtl/core/mer_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the midpoint ellipse rasterizer.
// Depends on mer_pkg; drives mer_datapath through cmd_t, reads status_t.
module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              command,
	input  mer_pkg::status_t  status,
	output logic              in_ready,
	output mer_pkg::cmd_t     cmd
);

	mer_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mer_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!command) begin
						state_d = mer_pkg::ST_S1;
					end else if (status.active && !status.region2) begin
						state_d = mer_pkg::ST_R1A;
					end else if (status.active) begin
						state_d = mer_pkg::ST_R2A;
					end
				end
			end
			mer_pkg::ST_S1:   state_d = mer_pkg::ST_S2;
			mer_pkg::ST_S2:   state_d = mer_pkg::ST_S3;
			mer_pkg::ST_S3:   state_d = mer_pkg::ST_S4;
			mer_pkg::ST_S4:   state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_R1A:  state_d = mer_pkg::ST_R1B;
			mer_pkg::ST_R1B:  state_d = mer_pkg::ST_R1C;
			mer_pkg::ST_R1C:  state_d = status.lt ? mer_pkg::ST_R1D : mer_pkg::ST_R2I1;
			mer_pkg::ST_R1D:  state_d = mer_pkg::ST_R1E;
			mer_pkg::ST_R1E:  state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_R2I1: state_d = mer_pkg::ST_R2I2;
			mer_pkg::ST_R2I2: state_d = mer_pkg::ST_R2I3;
			mer_pkg::ST_R2I3: state_d = mer_pkg::ST_R2I4;
			mer_pkg::ST_R2I4: state_d = mer_pkg::ST_R2I5;
			mer_pkg::ST_R2I5: state_d = mer_pkg::ST_R2I6;
			mer_pkg::ST_R2I6: state_d = mer_pkg::ST_R2I7;
			mer_pkg::ST_R2I7: state_d = mer_pkg::ST_R2I8;
			mer_pkg::ST_R2I8: state_d = mer_pkg::ST_R2A;
			mer_pkg::ST_R2A:  state_d = status.y_zero ? mer_pkg::ST_IDLE : mer_pkg::ST_R2B;
			mer_pkg::ST_R2B:  state_d = mer_pkg::ST_R2C;
			mer_pkg::ST_R2C:  state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_EMIT: begin
				if (status.emit_done) begin
					state_d = mer_pkg::ST_IDLE;
				end
			end
			default:          state_d = mer_pkg::ST_IDLE;
		endcase
	end

	// Outputs: input ready, multiplier select, register op, emit
	always_comb begin
		in_ready     = 1'b0;
		cmd.mul_sel  = mer_pkg::MUL_NONE;
		cmd.op       = mer_pkg::OP_NONE;
		cmd.emit     = 1'b0;
		unique case (state_q)
			mer_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !command) begin
					cmd.op = mer_pkg::OP_LOAD;
				end
			end
			mer_pkg::ST_S1: cmd.mul_sel = mer_pkg::MUL_RA_RA;
			mer_pkg::ST_S2: begin
				cmd.mul_sel = mer_pkg::MUL_RB_RB;
				cmd.op      = mer_pkg::OP_SET_A2;
			end
			mer_pkg::ST_S3: begin
				cmd.mul_sel = mer_pkg::MUL_A2_START;
				cmd.op      = mer_pkg::OP_SET_B2;
			end
			mer_pkg::ST_S4: cmd.op = mer_pkg::OP_DEC_START;
			mer_pkg::ST_R1A: cmd.mul_sel = mer_pkg::MUL_B2_X1;
			mer_pkg::ST_R1B: begin
				cmd.mul_sel = mer_pkg::MUL_A2_Y1;
				cmd.op      = mer_pkg::OP_LHS;
			end
			mer_pkg::ST_R1C: cmd.mul_sel = mer_pkg::MUL_B2_X3;
			mer_pkg::ST_R1D: begin
				cmd.mul_sel = mer_pkg::MUL_A2_Y2;
				cmd.op      = mer_pkg::OP_R1_ADD;
			end
			mer_pkg::ST_R1E: cmd.op = mer_pkg::OP_R1_FIN;
			mer_pkg::ST_R2I1: begin
				cmd.mul_sel = mer_pkg::MUL_SQX;
				cmd.op      = mer_pkg::OP_R2_ENTER;
			end
			mer_pkg::ST_R2I2: cmd.op = mer_pkg::OP_SQ;
			mer_pkg::ST_R2I3: cmd.mul_sel = mer_pkg::MUL_B2_SQ;
			mer_pkg::ST_R2I4: begin
				cmd.mul_sel = mer_pkg::MUL_SQY;
				cmd.op      = mer_pkg::OP_DEC_SET;
			end
			mer_pkg::ST_R2I5: cmd.op = mer_pkg::OP_SQ;
			mer_pkg::ST_R2I6: cmd.mul_sel = mer_pkg::MUL_A2_SQ;
			mer_pkg::ST_R2I7: begin
				cmd.mul_sel = mer_pkg::MUL_A2_B2;
				cmd.op      = mer_pkg::OP_DEC_ADD;
			end
			mer_pkg::ST_R2I8: cmd.op = mer_pkg::OP_DEC_SUB;
			mer_pkg::ST_R2A: begin
				if (status.y_zero) begin
					cmd.op = mer_pkg::OP_DEACT;
				end else begin
					cmd.mul_sel = mer_pkg::MUL_A2_Y3;
					cmd.op      = mer_pkg::OP_R2_CHK;
				end
			end
			mer_pkg::ST_R2B: begin
				cmd.mul_sel = mer_pkg::MUL_B2_X2;
				cmd.op      = mer_pkg::OP_DEC_ADD;
			end
			mer_pkg::ST_R2C: cmd.op = mer_pkg::OP_R2_FIN;
			mer_pkg::ST_EMIT: cmd.emit = 1'b1;
			default: ;
		endcase
	end

endmodule

>>> rtl/core/mer_datapath.sv
`timescale 1ns / 1ps
// Datapath of the midpoint ellipse rasterizer: point and decision registers,
// shared 21x21 multiplier with registered product, pixel output register.
// Depends on mer_pkg; controlled by mer_ctrl.
module mer_datapath #(
	parameter int SCREEN_WIDTH  = 256,
	parameter int SCREEN_HEIGHT = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mer_pkg::cmd_t       cmd,
	input  logic signed [7:0]   center_x,
	input  logic signed [7:0]   center_y,
	input  logic        [7:0]   radius_a,
	input  logic        [7:0]   radius_b,
	input  logic                out_ready,
	output mer_pkg::status_t    status,
	output logic                out_valid,
	output logic signed [9:0]   column,
	output logic signed [9:0]   row,
	output logic                on_screen,
	output logic                finished,
	output logic                last
);

	localparam int OPW = mer_pkg::OPW;
	localparam int PW  = mer_pkg::PW;
	localparam int DW  = mer_pkg::DW;
	localparam int PTW = mer_pkg::PTW;
	localparam int CW  = mer_pkg::CW;

	localparam logic signed [CW-1:0] HALF_W = CW'(SCREEN_WIDTH / 2);
	localparam logic signed [CW-1:0] HALF_H = CW'(SCREEN_HEIGHT / 2);
	localparam logic signed [CW-1:0] SCR_W  = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] SCR_H  = CW'(SCREEN_HEIGHT);

	// Item state
	logic signed [7:0]    cx_q, cy_q;
	logic        [7:0]    ra_q;
	logic        [15:0]   a2_q, b2_q;
	logic        [PTW-1:0] x_q, y_q;
	logic signed [DW-1:0] dec_q;
	logic                 dneg_q;
	logic signed [PW-1:0] lhs_q;
	logic signed [OPW-1:0] sq_q;
	logic                 active_q, region2_q;

	// Multiplier
	logic signed [OPW-1:0] opa, opb, xe, ye, a2e, b2e, rae;
	logic signed [PW-1:0]  prod_q;
	logic signed [DW-1:0]  p4, plow;

	// Output stage
	logic [1:0]           pix_q;
	logic                 out_valid_q, load_pix;
	logic signed [CW-1:0] cc, rc, xs, ys, col_c, row_c;
	logic signed [9:0]    column_q, row_q;
	logic                 on_screen_q, finished_q, last_q;

	assign xe  = signed'({{(OPW-PTW){1'b0}}, x_q});
	assign ye  = signed'({{(OPW-PTW){1'b0}}, y_q});
	assign a2e = signed'({{(OPW-16){1'b0}}, a2_q});
	assign b2e = signed'({{(OPW-16){1'b0}}, b2_q});
	assign rae = signed'({{(OPW-8){1'b0}}, ra_q});

	// Operand select
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cmd.mul_sel)
			mer_pkg::MUL_NONE: ;
			mer_pkg::MUL_RA_RA: begin
				opa = rae;
				opb = rae;
			end
			mer_pkg::MUL_RB_RB: begin
				opa = ye;
				opb = ye;
			end
			mer_pkg::MUL_A2_START: begin
				opa = a2e;
				opb = OPW'(1) - (ye <<< 2);
			end
			mer_pkg::MUL_B2_X1: begin
				opa = b2e;
				opb = xe + OPW'(1);
			end
			mer_pkg::MUL_A2_Y1: begin
				opa = a2e;
				opb = (ye <<< 1) - OPW'(1);
			end
			mer_pkg::MUL_B2_X3: begin
				opa = b2e;
				opb = (xe <<< 1) + OPW'(3);
			end
			mer_pkg::MUL_A2_Y2: begin
				opa = a2e;
				opb = OPW'(2) - (ye <<< 1);
			end
			mer_pkg::MUL_SQX: begin
				opa = (xe <<< 1) + OPW'(1);
				opb = (xe <<< 1) + OPW'(1);
			end
			mer_pkg::MUL_SQY: begin
				opa = ye - OPW'(1);
				opb = ye - OPW'(1);
			end
			mer_pkg::MUL_B2_SQ: begin
				opa = b2e;
				opb = sq_q;
			end
			mer_pkg::MUL_A2_SQ: begin
				opa = a2e;
				opb = sq_q;
			end
			mer_pkg::MUL_A2_B2: begin
				opa = a2e;
				opb = b2e;
			end
			mer_pkg::MUL_A2_Y3: begin
				opa = a2e;
				opb = OPW'(3) - (ye <<< 1);
			end
			mer_pkg::MUL_B2_X2: begin
				opa = b2e;
				opb = (xe <<< 1) + OPW'(2);
			end
			default: ;
		endcase
	end

	// Registered product
	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

	assign plow = prod_q[DW-1:0];
	assign p4   = {prod_q[DW-3:0], 2'b00};

	// Point, decision and scratch registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			mer_pkg::OP_LOAD: begin
				cx_q <= center_x;
				cy_q <= center_y;
				ra_q <= radius_a;
				x_q  <= '0;
				y_q  <= {{(PTW-8){1'b0}}, radius_b};
			end
			mer_pkg::OP_SET_A2:    a2_q <= prod_q[15:0];
			mer_pkg::OP_SET_B2:    b2_q <= prod_q[15:0];
			mer_pkg::OP_DEC_START: dec_q <= plow + signed'({{(DW-18){1'b0}}, b2_q, 2'b00});
			mer_pkg::OP_LHS:       lhs_q <= prod_q <<< 1;
			mer_pkg::OP_R1_ADD: begin
				dec_q  <= dec_q + p4;
				dneg_q <= dec_q[DW-1];
			end
			mer_pkg::OP_R1_FIN: begin
				if (!dneg_q) begin
					dec_q <= dec_q + p4;
					y_q   <= y_q - PTW'(1);
				end
				x_q <= x_q + PTW'(1);
			end
			mer_pkg::OP_SQ:      sq_q  <= prod_q[OPW-1:0];
			mer_pkg::OP_DEC_SET: dec_q <= plow;
			mer_pkg::OP_DEC_ADD: dec_q <= dec_q + p4;
			mer_pkg::OP_DEC_SUB: dec_q <= dec_q - p4;
			mer_pkg::OP_R2_CHK:  dneg_q <= dec_q[DW-1];
			mer_pkg::OP_R2_FIN: begin
				if (dneg_q) begin
					dec_q <= dec_q + p4;
					x_q   <= x_q + PTW'(1);
				end
				y_q <= y_q - PTW'(1);
			end
			default: ;
		endcase
	end

	// Pixel transfer into the output register
	assign load_pix = cmd.emit && (!out_valid_q || out_ready);

	// Control flags and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			region2_q   <= 1'b0;
			pix_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == mer_pkg::OP_LOAD) begin
				active_q  <= 1'b1;
				region2_q <= 1'b0;
			end else if (cmd.op == mer_pkg::OP_R2_ENTER) begin
				region2_q <= 1'b1;
			end else if (cmd.op == mer_pkg::OP_DEACT) begin
				active_q <= 1'b0;
			end else if (status.emit_done) begin
				active_q <= (y_q != '0);
			end
			if (load_pix) begin
				out_valid_q <= 1'b1;
				pix_q       <= pix_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Mirrored pixel: bit 0 picks -x, bit 1 picks -y
	always_comb begin
		cc    = HALF_W + CW'(cx_q);
		rc    = HALF_H - CW'(cy_q);
		xs    = signed'({{(CW-PTW){1'b0}}, x_q});
		ys    = signed'({{(CW-PTW){1'b0}}, y_q});
		col_c = pix_q[0] ? (cc - xs) : (cc + xs);
		row_c = pix_q[1] ? (rc + ys) : (rc - ys);
	end

	always_ff @(posedge clk) begin
		if (load_pix) begin
			column_q    <= col_c[9:0];
			row_q       <= row_c[9:0];
			on_screen_q <= !col_c[CW-1] && (col_c < SCR_W) && !row_c[CW-1] && (row_c < SCR_H);
			finished_q  <= (y_q == '0);
			last_q      <= (pix_q == 2'd3);
		end
	end

	assign status.active    = active_q;
	assign status.region2   = region2_q;
	assign status.lt        = lhs_q < prod_q;
	assign status.y_zero    = (y_q == '0);
	assign status.emit_done = load_pix && (pix_q == 2'd3);

	assign out_valid = out_valid_q;
	assign column    = column_q;
	assign row       = row_q;
	assign on_screen = on_screen_q;
	assign finished  = finished_q;
	assign last      = last_q;

endmodule

>>> rtl/core/midpoint_ellipse_rasterizer_unit.sv
`timescale 1ns / 1ps
// Midpoint ellipse rasterizer, top level.
// Depends on mer_pkg, mer_ctrl and mer_datapath.
//
// A start item (command 0) latches center and radii and yields the four mirrored
// pixels of the top point; each step item (command 1) advances one point along the
// curve and yields its four pixels, in the order (+x,+y), (-x,+y), (+x,-y), (-x,-y),
// with last set on the fourth. Steps after the final point (finished = 1) yield
// nothing. Off-screen pixels come out with on_screen = 0; column and row are the
// low ten bits of the exact value. One item is in work at a time, and the input
// is ready again once the fourth pixel sits in the output register. A step that crosses
// into region 2 first runs the region 2 setup, and a step while idle does no work. The
// time per item is set by the single shared 21x21 multiplier, which does one product
// per cycle with its result registered, and by the one-pixel output register, which
// sends one pixel per cycle while out_ready is high; a stalled output holds the item.
module midpoint_ellipse_rasterizer_unit #(
	parameter int SCREEN_WIDTH  = 256,
	parameter int SCREEN_HEIGHT = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic signed [7:0] center_x,
	input  logic signed [7:0] center_y,
	input  logic        [7:0] radius_a,
	input  logic        [7:0] radius_b,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [9:0] column,
	output logic signed [9:0] row,
	output logic              on_screen,
	output logic              finished,
	output logic              last
);

	mer_pkg::cmd_t    cmd;
	mer_pkg::status_t status;

	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	mer_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius_a  (radius_a),
		.radius_b  (radius_b),
		.out_ready (out_ready),
		.status    (status),
		.out_valid (out_valid),
		.column    (column),
		.row       (row),
		.on_screen (on_screen),
		.finished  (finished),
		.last      (last)
	);

	// A start always makes the block busy for its setup
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !command |=> !in_ready)
		else $error("start transfer did not begin setup");

	// Pixels of one item leave back to back: after a non-last pixel, the next is ready
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a pixel run");

	// A step while idle produces no work
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command && !status.active |=> in_ready && !status.active)
		else $error("idle step started work");

endmodule
